// File: design/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, codes and the CRC-16 byte update for the packet deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  // Frame phases of the receive sequencer
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6
  } phase_t;

  // End-of-frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_LEN     = 2'd2;
  localparam logic [1:0] ST_NOFRAME = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_ADDRESS = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] own_address;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [1:0]  status_code;
    logic [15:0] packet_length;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/crcdf_regs.sv
// ----------------------------------------------------------------------------
// crcdf_regs
// APB-style register file holding the header byte and station address.
// ----------------------------------------------------------------------------
module crcdf_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output crcdf_pkg::cfg_t      cfg
);

  logic [7:0] header_r;
  logic [7:0] address_r;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= 8'h00;
      address_r <= 8'h00;
    end else if (wr_en) begin
      unique case (reg_idx)
        crcdf_pkg::REG_HEADER:  header_r  <= pwdata[7:0];
        crcdf_pkg::REG_ADDRESS: address_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_idx)
      crcdf_pkg::REG_HEADER:  prdata = {24'h000000, header_r};
      crcdf_pkg::REG_ADDRESS: prdata = {24'h000000, address_r};
      default:                prdata = 32'h00000000;
    endcase
  end

  assign cfg.header_byte = header_r;
  assign cfg.own_address = address_r;

endmodule

// File: design/crcdf_seq.sv
// ----------------------------------------------------------------------------
// crcdf_seq
// Sequencer: phase, length counters, running CRC; a byte a cycle on byte_en.
// ----------------------------------------------------------------------------
module crcdf_seq #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_en,
  input  logic [7:0]           rx_byte,
  input  crcdf_pkg::cfg_t      cfg,
  output logic                 res_valid,
  output crcdf_pkg::result_t   res
);

  localparam logic [15:0] MaxLen = 16'(MAX_LEN);

  crcdf_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] left_dec;

  assign crc_upd  = crcdf_pkg::crc_byte(crc_r, rx_byte);
  assign len_full = {frame_len_r[15:8], rx_byte};
  assign left_dec = left_r - 16'd1;

  // Hold state between accepted bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crcdf_pkg::PH_HUNT;
      frame_len_r <= 16'h0000;
      left_r      <= 16'h0000;
      crc_r       <= crcdf_pkg::CRC_INIT;
      crc_hi_r    <= 8'h00;
    end else if (byte_en) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      left_r      <= left_nxt;
      crc_r       <= crc_nxt;
      crc_hi_r    <= crc_hi_nxt;
    end
  end

  // Advance the phase and form the result for this byte
  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    left_nxt      = left_r;
    crc_nxt       = crc_r;
    crc_hi_nxt    = crc_hi_r;
    res_valid     = 1'b0;
    res           = '0;
    unique case (phase_r)
      crcdf_pkg::PH_HUNT: begin
        if (rx_byte != cfg.header_byte) begin
          res_valid       = 1'b1;
          res.is_status   = 1'b1;
          res.status_code = crcdf_pkg::ST_NOFRAME;
        end else begin
          crc_nxt   = crcdf_pkg::CRC_INIT;
          phase_nxt = crcdf_pkg::PH_ADDR;
        end
      end
      crcdf_pkg::PH_ADDR: begin
        if (rx_byte != cfg.own_address) begin
          res_valid       = 1'b1;
          res.is_status   = 1'b1;
          res.status_code = crcdf_pkg::ST_NOFRAME;
          phase_nxt       = crcdf_pkg::PH_HUNT;
        end else begin
          phase_nxt = crcdf_pkg::PH_LEN_HI;
        end
      end
      crcdf_pkg::PH_LEN_HI: begin
        frame_len_nxt = {rx_byte, 8'h00};
        crc_nxt       = crc_upd;
        phase_nxt     = crcdf_pkg::PH_LEN_LO;
      end
      crcdf_pkg::PH_LEN_LO: begin
        frame_len_nxt = len_full;
        crc_nxt       = crc_upd;
        if (len_full > MaxLen) begin
          // Drop the frame at once
          res_valid         = 1'b1;
          res.is_status     = 1'b1;
          res.status_code   = crcdf_pkg::ST_LEN;
          res.packet_length = len_full;
          phase_nxt         = crcdf_pkg::PH_HUNT;
        end else begin
          left_nxt  = len_full;
          phase_nxt = (len_full == 16'h0000) ? crcdf_pkg::PH_CRC_HI
                                             : crcdf_pkg::PH_PAYLOAD;
        end
      end
      crcdf_pkg::PH_PAYLOAD: begin
        crc_nxt          = crc_upd;
        left_nxt         = left_dec;
        if (left_dec == 16'h0000) begin
          phase_nxt = crcdf_pkg::PH_CRC_HI;
        end
        res_valid        = 1'b1;
        res.payload_byte = rx_byte;
      end
      crcdf_pkg::PH_CRC_HI: begin
        crc_hi_nxt = rx_byte;
        phase_nxt  = crcdf_pkg::PH_CRC_LO;
      end
      crcdf_pkg::PH_CRC_LO: begin
        res_valid     = 1'b1;
        res.is_status = 1'b1;
        if ({crc_hi_r, rx_byte} == crc_r) begin
          res.status_code   = crcdf_pkg::ST_OK;
          res.packet_length = frame_len_r;
        end else begin
          res.status_code = crcdf_pkg::ST_CRC;
        end
        phase_nxt = crcdf_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = crcdf_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

// File: design/crcdf_outbuf.sv
// ----------------------------------------------------------------------------
// crcdf_outbuf
// Result register with a skid stage; decouples the sequencer from out_ready.
// ----------------------------------------------------------------------------
module crcdf_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crcdf_pkg::result_t   push_res,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crcdf_pkg::result_t   out_res
);

  logic               main_v_r;
  logic               skid_v_r;
  crcdf_pkg::result_t main_r;
  crcdf_pkg::result_t skid_r;
  logic               pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  // Valid flags: refill main from skid first, else from a new item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      main_v_r <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

endmodule

// File: design/crc16_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// Byte-serial frame receiver with CRC-16 check and a payload/status output.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per item (valid/ready). A new byte is taken in
//           every cycle while the result buffer has room.
//   out_* : payload bytes as they arrive, then one status item per frame
//           (ok, crc mismatch, length too large, no frame). A byte that makes
//           no result (header, own address, length, CRC high) emits nothing.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : register port; the
//           header byte sits at 0x0, the station address at 0x4.
// Each result is registered in the output register (or skid stage if full);
// one byte a cycle while in_ready is high, via combinational CRC/phase logic.
// A two-entry result buffer (output register plus skid stage) keeps input
// flowing while a result waits; in_ready drops only when both are full.
// Reset (rst_n low, synchronous) clears the registers to zero, empties the
// buffer and returns the sequencer to header hunting with CRC at 0xFFFF.
// MAX_LEN is the largest length field accepted as a frame.
// ----------------------------------------------------------------------------
module crc16_packet_deframer #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_status,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_status_code,
  output logic [15:0] out_packet_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  crcdf_pkg::cfg_t    cfg;
  crcdf_pkg::result_t seq_res;
  crcdf_pkg::result_t out_res;
  logic               seq_valid;
  logic               byte_en;
  logic               can_push;

  assign in_ready = can_push;
  assign byte_en  = in_valid && can_push;

  crcdf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crcdf_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg),
    .res_valid (seq_valid),
    .res       (seq_res)
  );

  crcdf_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_en && seq_valid),
    .push_res  (seq_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_is_status     = out_res.is_status;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_status_code   = out_res.status_code;
  assign out_packet_length = out_res.packet_length;

endmodule
